@@ rtl/core/bgos_pkg.sv @@
// shared constants for the barcode gap order scorer
`default_nettype none
package bgos_pkg;

    // transaction field widths
    localparam int KIND_W   = 2;
    localparam int LEN_W    = 27;
    localparam int BC_W     = 24;
    localparam int POS_IN_W = 28;
    localparam int SCORE_W  = 48;

    // default sizes
    localparam int MAX_ENTRIES_DEF   = 4096;
    localparam int MAX_LINES_DEF     = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POS    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

endpackage
`default_nettype wire

@@ rtl/core/bgos_if.sv @@
// valid/ready channel interfaces for items and results
`default_nettype none
interface bgos_item_if;
    logic                                  valid;
    logic                                  ready;
    logic [bgos_pkg::KIND_W-1:0]           kind;
    logic [bgos_pkg::LEN_W-1:0]            line_length;
    logic [bgos_pkg::BC_W-1:0]             barcode;
    logic signed [bgos_pkg::POS_IN_W-1:0]  position;

    modport source (output valid, kind, line_length, barcode, position, input ready);
    modport sink   (input valid, kind, line_length, barcode, position, output ready);
endinterface

interface bgos_result_if;
    logic                         valid;
    logic                         ready;
    logic [bgos_pkg::SCORE_W-1:0] score;
    logic                         dropped;
    logic                         last;

    modport source (output valid, score, dropped, last, input ready);
    modport sink   (input valid, score, dropped, last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/barcode_gap_order_score.sv @@
// Barcode gap order scorer. Start items (kind 0) and position items (kind 1) load a
// store of (barcode, line, offset position) entries kept sorted by insertion: a start
// item only updates the line and overflow state, a position item into an empty store
// is written directly, and otherwise the insertion walks the store one entry per cycle
// through its single read and single write port, moving up each stored entry that
// sorts after the new one. A finish item (kind 2) walks the sorted store one entry per
// cycle to find each barcode group, then walks each scored group again pair by pair;
// every pair that crosses to a later line with a ratio of at least 2 runs the 48-step
// divider unless its quotient cannot fit, which saturates the total. The single result
// waits in an output register; no item is taken until it has gone. The store needs no
// clearing after reset: entries beyond the fill count are never read.
`default_nettype none
module barcode_gap_order_score #(
    parameter int MAX_ENTRIES   = bgos_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_LINES     = bgos_pkg::MAX_LINES_DEF,
    parameter int FRACTION_BITS = bgos_pkg::FRACTION_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bgos_item_if.sink     item,
    bgos_result_if.source result
);

    localparam int BC_W    = bgos_pkg::BC_W;
    localparam int SCORE_W = bgos_pkg::SCORE_W;
    localparam int LINE_W  = $clog2(MAX_LINES);
    localparam int LI_W    = $clog2(MAX_LINES + 2);
    localparam int OFF_W   = bgos_pkg::LEN_W + LINE_W;
    localparam int POS_W   = OFF_W + 2;
    localparam int GAP_W   = POS_W + 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W  = $clog2(MAX_ENTRIES);
    localparam int NUM_W   = GAP_W + CNT_W;
    localparam int PROD_W  = NUM_W + 1;
    localparam int CW      = NUM_W + SCORE_W;
    localparam int EW      = BC_W + LINE_W + POS_W;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_CMP  = 4'd1;
    localparam logic [3:0] S_INS_LAST = 4'd2;
    localparam logic [3:0] S_G_FIRST  = 4'd3;
    localparam logic [3:0] S_G_SCAN   = 4'd4;
    localparam logic [3:0] S_G_END    = 4'd5;
    localparam logic [3:0] S_G_NEXT   = 4'd6;
    localparam logic [3:0] S_P_PREV   = 4'd7;
    localparam logic [3:0] S_P_PAIR   = 4'd8;
    localparam logic [3:0] S_P_MUL    = 4'd9;
    localparam logic [3:0] S_P_NORM   = 4'd10;
    localparam logic [3:0] S_P_CHK    = 4'd11;
    localparam logic [3:0] S_P_DIV    = 4'd12;
    localparam logic [3:0] S_P_ADV    = 4'd13;

    typedef struct packed {
        logic [BC_W-1:0]         bc;
        logic [LINE_W-1:0]       line;
        logic signed [POS_W-1:0] pos;
    } entry_t;

    // control registers
    logic [3:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [LI_W-1:0]        line_idx_reg, line_idx_next;
    logic [OFF_W-1:0]       offset_reg, offset_next;
    logic [bgos_pkg::LEN_W-1:0] cur_len_reg, cur_len_next;
    logic                   ovf_reg, ovf_next;
    logic                   out_valid_reg, out_valid_next;

    // working registers
    entry_t                 new_reg, new_next;
    entry_t                 prev_reg, prev_next;
    entry_t                 cur_reg, cur_next;
    logic [ADDR_W-1:0]      ins_idx_reg, ins_idx_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic [CNT_W-1:0]       l_reg, l_next;
    logic [CNT_W-1:0]       z_reg, z_next;
    logic [BC_W-1:0]        first_bc_reg, first_bc_next;
    logic signed [POS_W-1:0] first_pos_reg, first_pos_next;
    logic signed [POS_W-1:0] last_pos_reg, last_pos_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic signed [GAP_W-1:0] span_reg, span_next;
    logic signed [GAP_W-1:0] gap_reg, gap_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] numv_reg, numv_next;
    logic [GAP_W-1:0]       den_reg, den_next;
    logic [SCORE_W-1:0]     total_reg, total_next;
    logic [SCORE_W-1:0]     score_reg, score_next;
    logic                   dropped_reg, dropped_next;

    // memory and divider hookup
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    entry_t                 mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [EW-1:0]          mem_rdata;
    entry_t                 rd_e;
    logic                   div_start;
    logic                   div_done;
    logic [SCORE_W-1:0]     div_quo;

    logic                   in_fire;
    logic                   out_fire;
    logic [SCORE_W:0]       add_sum;
    logic [SCORE_W-1:0]     add_val;
    logic [NUM_W-1:0]       num_mag;
    entry_t                 in_entry;

    function automatic logic entry_gt(entry_t a, entry_t b);
        logic r;
        r = (a.bc > b.bc) ||
            ((a.bc == b.bc) && ((a.line > b.line) ||
                                ((a.line == b.line) && (a.pos > b.pos))));
        return r;
    endfunction

    assign in_fire  = item.valid && item.ready;
    assign out_fire = result.valid && result.ready;
    assign rd_e     = entry_t'(mem_rdata);
    assign num_mag  = numv_reg[NUM_W-1:0];

    // entry built from a position transaction
    always_comb
    begin
        in_entry.bc   = item.barcode;
        in_entry.line = LINE_W'(line_idx_reg - 1'b1);
        in_entry.pos  = $signed({2'b00, offset_reg}) + POS_W'(item.position);
    end

    // saturating accumulate
    always_comb
    begin
        add_val = (state_reg == S_P_DIV) ? div_quo : bgos_pkg::SCORE_MAX;
        add_sum = {1'b0, total_reg} + {1'b0, add_val};
    end

    bgos_mem #(
        .WIDTH  (EW),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (EW'(mem_wdata)),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bgos_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (GAP_W),
        .FRAC_W (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_mag),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // read address chosen for the data the next state consumes
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:    mem_raddr = (item.kind == bgos_pkg::KIND_FINISH) ? '0
                                   : ADDR_W'(count_reg - 1'b1);
            S_INS_CMP: mem_raddr = ins_idx_reg - ADDR_W'(2);
            S_G_FIRST: mem_raddr = ADDR_W'(k_reg + 1'b1);
            S_G_SCAN:  mem_raddr = ADDR_W'(j_reg + 1'b1);
            S_G_END:   mem_raddr = ADDR_W'(k_reg);
            S_G_NEXT:  mem_raddr = ADDR_W'(l_reg);
            S_P_PREV:  mem_raddr = ADDR_W'(k_reg + 1'b1);
            default:   mem_raddr = ADDR_W'(z_reg + 1'b1);
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        line_idx_next  = line_idx_reg;
        offset_next    = offset_reg;
        cur_len_next   = cur_len_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        new_next       = new_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        ins_idx_next   = ins_idx_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        l_next         = l_reg;
        z_next         = z_reg;
        first_bc_next  = first_bc_reg;
        first_pos_next = first_pos_reg;
        last_pos_next  = last_pos_reg;
        n_next         = n_reg;
        span_next      = span_reg;
        gap_next       = gap_reg;
        prod_next      = prod_reg;
        numv_next      = numv_reg;
        den_next       = den_reg;
        total_next     = total_reg;
        score_next     = score_reg;
        dropped_next   = dropped_reg;
        mem_we         = 1'b0;
        mem_waddr      = ins_idx_reg;
        mem_wdata      = new_reg;
        div_start      = 1'b0;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (item.kind)
                        bgos_pkg::KIND_START:
                        begin
                            if (line_idx_reg >= LI_W'(MAX_LINES))
                            begin
                                line_idx_next = LI_W'(MAX_LINES + 1);
                                ovf_next      = 1'b1;
                            end
                            else
                            begin
                                offset_next   = offset_reg + OFF_W'(cur_len_reg);
                                cur_len_next  = item.line_length;
                                line_idx_next = line_idx_reg + 1'b1;
                            end
                        end
                        bgos_pkg::KIND_POS:
                        begin
                            if (line_idx_reg == '0)
                            begin
                                ovf_next = ovf_reg;
                            end
                            else if (line_idx_reg > LI_W'(MAX_LINES) ||
                                     count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = in_entry;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                new_next     = in_entry;
                                ins_idx_next = ADDR_W'(count_reg);
                                state_next   = S_INS_CMP;
                            end
                        end
                        bgos_pkg::KIND_FINISH:
                        begin
                            total_next = '0;
                            k_next     = '0;
                            if (count_reg < CNT_W'(2))
                            begin
                                score_next     = '0;
                                dropped_next   = ovf_reg;
                                out_valid_next = 1'b1;
                                count_next     = '0;
                                line_idx_next  = '0;
                                offset_next    = '0;
                                cur_len_next   = '0;
                                ovf_next       = 1'b0;
                            end
                            else
                            begin
                                state_next = S_G_FIRST;
                            end
                        end
                        default:
                        begin
                            ovf_next = ovf_reg;
                        end
                    endcase
                end
            end

            // shift larger entries up one slot until the new entry fits
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (entry_gt(rd_e, new_reg))
                begin
                    mem_wdata    = rd_e;
                    ins_idx_next = ins_idx_reg - 1'b1;
                    if (ins_idx_reg == ADDR_W'(1))
                    begin
                        state_next = S_INS_LAST;
                    end
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_INS_LAST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                count_next = count_reg + 1'b1;
                state_next = S_IDLE;
            end

            // first entry of a barcode group
            S_G_FIRST:
            begin
                first_bc_next  = rd_e.bc;
                first_pos_next = rd_e.pos;
                last_pos_next  = rd_e.pos;
                j_next         = k_reg + 1'b1;
                if (k_reg + 1'b1 == count_reg)
                begin
                    l_next     = count_reg;
                    state_next = S_G_END;
                end
                else
                begin
                    state_next = S_G_SCAN;
                end
            end

            // find the end of the group
            S_G_SCAN:
            begin
                if (rd_e.bc == first_bc_reg)
                begin
                    last_pos_next = rd_e.pos;
                    j_next        = j_reg + 1'b1;
                    if (j_reg + 1'b1 == count_reg)
                    begin
                        l_next     = count_reg;
                        state_next = S_G_END;
                    end
                end
                else
                begin
                    l_next     = j_reg;
                    state_next = S_G_END;
                end
            end

            // group size and span decide whether pairs are scored
            S_G_END:
            begin
                n_next    = l_reg - k_reg - 1'b1;
                span_next = GAP_W'(last_pos_reg) - GAP_W'(first_pos_reg);
                if ((l_reg - k_reg >= CNT_W'(2)) && (last_pos_reg != first_pos_reg))
                begin
                    state_next = S_P_PREV;
                end
                else
                begin
                    state_next = S_G_NEXT;
                end
            end

            S_G_NEXT:
            begin
                k_next = l_reg;
                if (l_reg == count_reg)
                begin
                    score_next     = total_reg;
                    dropped_next   = ovf_reg;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    line_idx_next  = '0;
                    offset_next    = '0;
                    cur_len_next   = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_G_FIRST;
                end
            end

            S_P_PREV:
            begin
                prev_next  = rd_e;
                z_next     = k_reg + 1'b1;
                state_next = S_P_PAIR;
            end

            // consecutive pair: only a rise in line index counts
            S_P_PAIR:
            begin
                cur_next = rd_e;
                if (rd_e.line > prev_reg.line)
                begin
                    gap_next   = GAP_W'(rd_e.pos) - GAP_W'(prev_reg.pos);
                    state_next = S_P_MUL;
                end
                else
                begin
                    state_next = S_P_ADV;
                end
            end

            S_P_MUL:
            begin
                prod_next  = gap_reg * $signed({1'b0, n_reg});
                state_next = S_P_NORM;
            end

            // move the span sign onto the numerator
            S_P_NORM:
            begin
                if (span_reg < 0)
                begin
                    numv_next = -prod_reg;
                    den_next  = GAP_W'(-span_reg);
                end
                else
                begin
                    numv_next = prod_reg;
                    den_next  = GAP_W'(span_reg);
                end
                state_next = S_P_CHK;
            end

            // ratio at least 2, saturate when the quotient cannot fit
            S_P_CHK:
            begin
                if (numv_reg < 0 || {1'b0, num_mag} < {den_reg, 1'b0})
                begin
                    state_next = S_P_ADV;
                end
                else if (CW'(num_mag) >= (CW'(den_reg) << (SCORE_W - FRACTION_BITS)))
                begin
                    total_next = bgos_pkg::SCORE_MAX;
                    state_next = S_P_ADV;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_P_DIV;
                end
            end

            S_P_DIV:
            begin
                if (div_done)
                begin
                    total_next = add_sum[SCORE_W] ? bgos_pkg::SCORE_MAX
                                                  : add_sum[SCORE_W-1:0];
                    state_next = S_P_ADV;
                end
            end

            S_P_ADV:
            begin
                prev_next = cur_reg;
                z_next    = z_reg + 1'b1;
                if (z_reg + 1'b1 == l_reg)
                begin
                    state_next = S_G_NEXT;
                end
                else
                begin
                    state_next = S_P_PAIR;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            line_idx_reg  <= '0;
            offset_reg    <= '0;
            cur_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            line_idx_reg  <= line_idx_next;
            offset_reg    <= offset_next;
            cur_len_reg   <= cur_len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        new_reg       <= new_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        ins_idx_reg   <= ins_idx_next;
        k_reg         <= k_next;
        j_reg         <= j_next;
        l_reg         <= l_next;
        z_reg         <= z_next;
        first_bc_reg  <= first_bc_next;
        first_pos_reg <= first_pos_next;
        last_pos_reg  <= last_pos_next;
        n_reg         <= n_next;
        span_reg      <= span_next;
        gap_reg       <= gap_next;
        prod_reg      <= prod_next;
        numv_reg      <= numv_next;
        den_reg       <= den_next;
        total_reg     <= total_next;
        score_reg     <= score_next;
        dropped_reg   <= dropped_next;
    end

    assign item.ready     = (state_reg == S_IDLE) && !out_valid_reg;
    assign result.valid   = out_valid_reg;
    assign result.score   = score_reg;
    assign result.dropped = dropped_reg;
    assign result.last    = 1'b1;

endmodule
`default_nettype wire

@@ rtl/core/bgos_mem.sv @@
// entry store: one write port, one registered read port
`default_nettype none
module bgos_mem #(
    parameter int WIDTH  = 60,
    parameter int DEPTH  = bgos_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/core/bgos_div.sv @@
// restoring divider: floor(num * 2^FRAC_W / den), one quotient bit per cycle
`default_nettype none
module bgos_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 35,
    parameter int FRAC_W = bgos_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [NUM_W-1:0]              num,
    input  wire logic [DEN_W-1:0]              den,
    output logic                               done,
    output logic [bgos_pkg::SCORE_W-1:0]       quo
);

    localparam int QW   = bgos_pkg::SCORE_W;
    localparam int NXW  = NUM_W + FRAC_W + QW;
    localparam int CN_W = $clog2(QW + 1);

    logic [NXW-1:0]   nx;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]    sh_reg, sh_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CN_W-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // scaled dividend; caller guarantees the quotient fits QW bits
    assign nx    = {{QW{1'b0}}, num, {FRAC_W{1'b0}}};
    assign trial = {rem_reg, sh_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};

    // one shift and subtract step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = DEN_W'(nx[NXW-1:QW]);
            sh_next   = nx[QW-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                sh_next  = {sh_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                sh_next  = {sh_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CN_W'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule
`default_nettype wire

@@ tb/barcode_gap_order_score_test.sv @@
// self-checking testbench for the barcode gap order scorer
`timescale 1ns / 1ps
module barcode_gap_order_score_test;

    localparam int MAX_ENTRIES   = bgos_pkg::MAX_ENTRIES_DEF;
    localparam int MAX_LINES     = bgos_pkg::MAX_LINES_DEF;
    localparam int FRACTION_BITS = bgos_pkg::FRACTION_BITS_DEF;
    localparam int KIND_W        = bgos_pkg::KIND_W;
    localparam int LEN_W         = bgos_pkg::LEN_W;
    localparam int BC_W          = bgos_pkg::BC_W;
    localparam int POS_IN_W      = bgos_pkg::POS_IN_W;
    localparam int SCORE_W       = bgos_pkg::SCORE_W;
    localparam logic [KIND_W-1:0] KIND_START  = bgos_pkg::KIND_START;
    localparam logic [KIND_W-1:0] KIND_POS    = bgos_pkg::KIND_POS;
    localparam logic [KIND_W-1:0] KIND_FINISH = bgos_pkg::KIND_FINISH;
    localparam int KIND_UNUSED   = 3;

    typedef struct {
        logic [KIND_W-1:0]          kind;
        logic [LEN_W-1:0]           len;
        logic [BC_W-1:0]            bc;
        logic signed [POS_IN_W-1:0] pos;
        bit                         drain;
    } load_item_t;

    typedef struct {
        int unsigned bc;
        int unsigned line;
        longint      pos;
    } placed_entry_t;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic               dropped;
    } score_result_t;

    logic clk;
    logic rst_n;
    bit   failed;
    bit   quiet_tail;

    bgos_item_if   item();
    bgos_result_if result();

    barcode_gap_order_score dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    always #5 clk = ~clk;

    // scorer state mirrored on the testbench side
    load_item_t    pending_items[$];
    score_result_t expected_scores[$];
    placed_entry_t sorted_entries[$];
    int unsigned   lines_started;
    longint        line_base;
    longint        current_len;
    bit            dropped_flag;

    function automatic bit entry_after(placed_entry_t a, placed_entry_t b);
        if (a.bc != b.bc) return a.bc > b.bc;
        if (a.line != b.line) return a.line > b.line;
        return a.pos > b.pos;
    endfunction

    function automatic logic [SCORE_W-1:0] group_gap_score();
        longint unsigned total;
        longint unsigned smax;
        int k;
        int l;
        int z;
        longint n;
        longint span;
        longint num;
        longint den;
        longint unsigned q;
        longint unsigned r;
        longint unsigned v;
        total = 0;
        smax  = (64'd1 << SCORE_W) - 1;
        k = 0;
        while (k < sorted_entries.size())
        begin
            l = k + 1;
            while (l < sorted_entries.size() && sorted_entries[l].bc == sorted_entries[k].bc)
                l++;
            n    = l - k - 1;
            span = sorted_entries[l-1].pos - sorted_entries[k].pos;
            // zero span and single entry groups add nothing
            if (n >= 1 && span != 0)
            begin
                for (z = k + 1; z < l; z++)
                begin
                    if (sorted_entries[z].line <= sorted_entries[z-1].line) continue;
                    num = (sorted_entries[z].pos - sorted_entries[z-1].pos) * n;
                    den = span;
                    if (den < 0)
                    begin
                        num = -num;
                        den = -den;
                    end
                    if (num < 2 * den) continue;
                    q = num / den;
                    r = num % den;
                    if (q > (smax >> FRACTION_BITS))
                        v = smax;
                    else
                        v = (q << FRACTION_BITS) + ((r << FRACTION_BITS) / den);
                    if (v >= smax || total > smax - v)
                        total = smax;
                    else
                        total = total + v;
                end
            end
            k = l;
        end
        return total[SCORE_W-1:0];
    endfunction

    function automatic void clear_run();
        sorted_entries.delete();
        lines_started = 0;
        line_base     = 0;
        current_len   = 0;
        dropped_flag  = 0;
    endfunction

    // update the mirrored state for one accepted transaction
    function automatic void apply_item(load_item_t t);
        placed_entry_t e;
        score_result_t res;
        int i;
        unique case (t.kind)
            KIND_START:
            begin
                if (lines_started >= MAX_LINES)
                begin
                    lines_started = MAX_LINES + 1;
                    dropped_flag  = 1;
                end
                else
                begin
                    line_base     += current_len;
                    current_len   = longint'(t.len);
                    lines_started++;
                end
            end
            KIND_POS:
            begin
                if (lines_started == 0)
                    ;
                else if (lines_started > MAX_LINES || sorted_entries.size() >= MAX_ENTRIES)
                    dropped_flag = 1;
                else
                begin
                    e.bc   = 32'(t.bc);
                    e.line = lines_started - 1;
                    e.pos  = line_base + longint'(t.pos);
                    i = sorted_entries.size();
                    while (i > 0 && entry_after(sorted_entries[i-1], e))
                        i--;
                    sorted_entries.insert(i, e);
                end
            end
            KIND_FINISH:
            begin
                res.score   = group_gap_score();
                res.dropped = dropped_flag;
                expected_scores.insert(expected_scores.size(), res);
                clear_run();
            end
            default: ;
        endcase
    endfunction

    // stimulus helpers
    task automatic push_item(int kind, logic [LEN_W-1:0] len, logic [BC_W-1:0] bc,
                             logic signed [POS_IN_W-1:0] pos, bit drain = 0);
        load_item_t t;
        t.kind  = KIND_W'(kind);
        t.len   = len;
        t.bc    = bc;
        t.pos   = pos;
        t.drain = drain;
        pending_items.insert(pending_items.size(), t);
    endtask

    task automatic push_start(logic [LEN_W-1:0] len);
        push_item(KIND_START, len, BC_W'($urandom), POS_IN_W'($urandom));
    endtask

    task automatic push_pos(logic [BC_W-1:0] bc, logic signed [POS_IN_W-1:0] pos);
        push_item(KIND_POS, LEN_W'($urandom), bc, pos);
    endtask

    task automatic push_finish(bit drain = 0);
        push_item(KIND_FINISH, LEN_W'($urandom), BC_W'($urandom), POS_IN_W'($urandom),
                  drain);
    endtask

    // one random scoring run with well-formed lines and some noise
    task automatic random_run(int n_lines);
        int li;
        int p;
        int n_pos;
        int bc_pool;
        logic [LEN_W-1:0] len;
        logic [BC_W-1:0] bc;
        logic signed [POS_IN_W-1:0] pos;
        bc_pool = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5);
        for (li = 0; li < n_lines; li++)
        begin
            case ($urandom_range(0, 3))
                0: len = LEN_W'($urandom);
                1: len = LEN_W'($urandom_range(0, 20));
                default: len = LEN_W'($urandom_range(0, 100000));
            endcase
            push_start(len);
            n_pos = $urandom_range(0, 6);
            for (p = 0; p < n_pos; p++)
            begin
                bc = bc_pool == 0 ? BC_W'($urandom) : BC_W'($urandom_range(0, bc_pool));
                case ($urandom_range(0, 3))
                    0: pos = POS_IN_W'($urandom);
                    1: pos = POS_IN_W'(int'($urandom_range(0, 40)) - 20);
                    default: pos = POS_IN_W'($urandom_range(0, 200000));
                endcase
                push_pos(bc, pos);
                if ($urandom_range(0, 30) == 0)
                    push_item(KIND_UNUSED, LEN_W'($urandom), BC_W'($urandom),
                              POS_IN_W'($urandom));
            end
        end
        push_finish();
    endtask

    // item driver
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid       <= 1'b0;
            item.kind        <= '0;
            item.line_length <= '0;
            item.barcode     <= '0;
            item.position    <= '0;
            send_gap         = 0;
        end
        else
        begin
            if (item.valid && item.ready)
                apply_item('{item.kind, item.line_length, item.barcode, item.position, 1'b0});
            if (!item.valid || item.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item.valid <= 1'b0;
                end
                else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain && expected_scores.size() > 0))
                begin
                    load_item_t t;
                    t = pending_items.pop_front();
                    item.valid       <= 1'b1;
                    item.kind        <= t.kind;
                    item.line_length <= t.len;
                    item.barcode     <= t.bc;
                    item.position    <= t.pos;
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 16);
                end
                else
                    item.valid <= 1'b0;
            end
        end
    end

    // result monitor with random backpressure
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_left   = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $error("unexpected result transaction: score %0h", result.score);
                    failed = 1;
                end
                else
                begin
                    score_result_t exp_r;
                    exp_r = expected_scores.pop_front();
                    if (result.score !== exp_r.score)
                    begin
                        $error("score: expected %0h, got %0h", exp_r.score, result.score);
                        failed = 1;
                    end
                    if (result.dropped !== exp_r.dropped)
                    begin
                        $error("dropped: expected %0b, got %0b", exp_r.dropped, result.dropped);
                        failed = 1;
                    end
                    if (result.last !== 1'b1)
                    begin
                        $error("last: expected 1, got %0b", result.last);
                        failed = 1;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 16);
            end
        end
    end

    // run limit
    initial
    begin
        #30ms;
        $display("tb: failure");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        int i;
        clk        = 1'b0;
        rst_n      = 1'b0;
        failed     = 0;
        quiet_tail = 0;
        clear_run();

        // directed: stray items, empty finish, extremes
        push_pos(24'h000001, 28'sd5);
        push_item(KIND_UNUSED, '1, '1, '1);
        push_finish();
        push_start('1);
        push_pos('1, {1'b1, {(POS_IN_W-1){1'b0}}});
        push_start(27'd0);
        push_pos('1, {1'b0, {(POS_IN_W-1){1'b1}}});
        push_pos(24'd0, 28'sd0);
        push_finish();
        // zero span group across two lines
        push_start(27'd0);
        push_pos(24'd7, 28'sd100);
        push_start(27'd0);
        push_pos(24'd7, 28'sd100);
        push_finish();
        // positive span and a large jump back
        push_start(27'd0);
        push_pos(24'd9, 28'sd1000);
        push_pos(24'd9, 28'sd0);
        push_start(27'd0);
        push_pos(24'd9, -28'sd5000);
        push_start(27'd0);
        push_pos(24'd9, 28'sd90000);
        push_finish(1);
        // too many lines
        for (i = 0; i < MAX_LINES + 2; i++)
        begin
            push_start(27'd10);
            push_pos(24'd3, POS_IN_W'(i * 997 % 50));
        end
        push_finish();

        // random scoring runs
        i = 0;
        while (i < 1640)
        begin
            int nl;
            nl = $urandom_range(0, 15) == 0 ? $urandom_range(15, 18) : $urandom_range(1, 5);
            random_run(nl);
            i = i + 4 * nl + 1;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_items.size() < 150);
        quiet_tail = 1;
        while (pending_items.size() > 0 || item.valid || expected_scores.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (!failed && expected_scores.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
